// File: rtl/core/lslf_pkg.sv
`timescale 1ns / 1ps

package lslf_pkg;

	localparam int MAX_POINTS_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int FIELD_W  = 16;
	localparam int OUT_W    = 48;
	localparam int FRAC_W   = 17;

	localparam logic [OUT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x_value;
		logic signed [FIELD_W-1:0] y_value;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] slope_out;
		logic signed [OUT_W-1:0] intercept_out;
		logic                    degenerate;
	} fit_t;

endpackage

// File: rtl/core/least_squares_line_fit_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+--------------------------------
// point     | in        | start high while busy low   | x_value, y_value, last_point
// result    | out       | done high for one cycle     | slope_out, intercept_out,
//           |           |                             | degenerate
//
// Points are taken one per cycle while busy is low; each is summed at its accept edge
// unless MAX_POINTS are already held, when it is dropped. A transaction with
// last_point set raises busy while one shared adder runs the fit: six shift-add product
// passes and two restoring divisions, or only the two D passes when degenerate. Reset
// clears the sequencer, point count and all sums at once.
// The receiver cannot stall: done is high for exactly one cycle and result is valid with it.

module least_squares_line_fit_top
	import lslf_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  point_t point,
	output logic   done,
	output fit_t   result
);

	// Sizing: count, sums of samples, sums of products, fit numerators, adder.
	localparam int S    = SAMPLE_BITS;
	localparam int RW   = (S > FIELD_W) ? S : FIELD_W;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SW   = S + CW;
	localparam int PW   = 2 * S + CW;
	localparam int NW   = SW + PW + 1;
	localparam int AW   = (NW + FRAC_W + 1 > OUT_W + 1) ? NW + FRAC_W + 1 : OUT_W + 1;
	localparam int CNTW = $clog2(AW + 1);

	// Product passes: D = n*Sxx - Sx*Sx, slope num = n*Sxy - Sx*Sy,
	// intercept num = Sy*Sxx - Sx*Sxy. Odd passes subtract.
	localparam logic [2:0] PASS_D_POS = 3'd0;
	localparam logic [2:0] PASS_D_NEG = 3'd1;
	localparam logic [2:0] PASS_S_POS = 3'd2;
	localparam logic [2:0] PASS_S_NEG = 3'd3;
	localparam logic [2:0] PASS_I_POS = 3'd4;
	localparam logic [2:0] PASS_I_NEG = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_DCHK,
		ST_DABS,
		ST_NABS,
		ST_NADD,
		ST_DIV,
		ST_SAT
	} state_t;

	state_t state_q;

	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] sx_q;
	logic signed [SW-1:0] sy_q;
	logic signed [PW-1:0] sxy_q;
	logic signed [PW-1:0] sxx_q;

	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   mcand_q;
	logic [SW-1:0]   mplier_q;
	logic [AW-1:0]   d_q;
	logic [AW-1:0]   rem_q;
	logic [AW-1:0]   nq_q;
	logic [CNTW-1:0] cnt_q;
	logic [2:0]      pass_q;
	logic            dneg_q;
	logic            qneg_q;
	logic            done_q;
	fit_t            result_q;

	// Sample extraction: low SAMPLE_BITS of the field, sign-extended.
	logic [RW-1:0]         x_raw;
	logic [RW-1:0]         y_raw;
	logic signed [S-1:0]   x_smp;
	logic signed [S-1:0]   y_smp;
	logic signed [2*S-1:0] pxy;
	logic signed [2*S-1:0] pxx;
	logic                  accept;
	logic                  room;

	assign x_raw  = RW'($unsigned(point.x_value));
	assign y_raw  = RW'($unsigned(point.y_value));
	assign x_smp  = signed'(x_raw[S-1:0]);
	assign y_smp  = signed'(y_raw[S-1:0]);
	assign pxy    = x_smp * y_smp;
	assign pxx    = x_smp * x_smp;
	assign accept = start && !busy;
	assign room   = count_q < CW'(MAX_POINTS);

	// Pass operand select: multiplicand a, multiplier b.
	logic signed [AW-1:0] op_a;
	logic [SW-1:0]        op_b;

	always_comb begin
		case (pass_q)
			PASS_D_POS: begin
				op_a = AW'(sxx_q);
				op_b = SW'(count_q);
			end
			PASS_D_NEG: begin
				op_a = AW'(sx_q);
				op_b = sx_q;
			end
			PASS_S_POS: begin
				op_a = AW'(sxy_q);
				op_b = SW'(count_q);
			end
			PASS_S_NEG: begin
				op_a = AW'(sy_q);
				op_b = sx_q;
			end
			PASS_I_POS: begin
				op_a = AW'(sxx_q);
				op_b = sy_q;
			end
			PASS_I_NEG: begin
				op_a = AW'(sxy_q);
				op_b = sx_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Shared adder/subtractor; carry out doubles as the unsigned a >= b flag.
	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic          add_sub;
	logic [AW:0]   add_sum;

	logic            mac_last;
	logic            mac_neg;
	logic [AW-1:0]   r_sh;
	logic            q_big;
	logic [OUT_W-1:0] sat_m;
	logic [OUT_W-1:0] limit;

	assign mac_last = cnt_q == CNTW'(SW - 1);
	// Two's complement multiplier: the top bit weighs negative.
	assign mac_neg  = pass_q[0] ^ mac_last;
	assign r_sh     = {rem_q[AW-2:0], nq_q[AW-1]};
	assign limit    = qneg_q ? NEG_LIMIT : POS_LIMIT;
	assign q_big    = nq_q > AW'(limit);
	assign sat_m    = q_big ? limit : nq_q[OUT_W-1:0];

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_MAC: begin
				add_a   = acc_q;
				add_b   = mcand_q;
				add_sub = mac_neg;
			end
			ST_DABS: begin
				add_b   = acc_q;
				add_sub = dneg_q;
			end
			ST_NABS: begin
				add_b   = acc_q;
				add_sub = acc_q[AW-1];
			end
			ST_NADD: begin
				// Rounded quotient: (|num| << FRAC + |D|) / (2|D|).
				add_a = acc_q << FRAC_W;
				add_b = d_q;
			end
			ST_DIV: begin
				add_a   = r_sh;
				add_b   = d_q << 1;
				add_sub = 1'b1;
			end
			ST_SAT: begin
				add_b   = AW'(sat_m);
				add_sub = qneg_q;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW + 1)'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxy_q   <= '0;
			sxx_q   <= '0;
			pass_q  <= PASS_D_POS;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CW'(1);
							sx_q    <= sx_q + SW'(x_smp);
							sy_q    <= sy_q + SW'(y_smp);
							sxy_q   <= sxy_q + PW'(pxy);
							sxx_q   <= sxx_q + PW'(pxx);
						end
						if (point.last_point) begin
							pass_q  <= PASS_D_POS;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					mcand_q  <= op_a;
					mplier_q <= op_b;
					cnt_q    <= '0;
					if (!pass_q[0]) begin
						acc_q <= '0;
					end
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (mplier_q[0]) begin
						acc_q <= add_sum[AW-1:0];
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + CNTW'(1);
					if (mac_last) begin
						if (pass_q == PASS_D_NEG) begin
							state_q <= ST_DCHK;
						end else if (pass_q[0]) begin
							state_q <= ST_NABS;
						end else begin
							pass_q  <= pass_q + 3'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DCHK: begin
					if (count_q < CW'(2) || acc_q == '0) begin
						// One point or all x equal: flagged, zero line.
						result_q.slope_out     <= '0;
						result_q.intercept_out <= '0;
						result_q.degenerate    <= 1'b1;
						done_q  <= 1'b1;
						count_q <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						sxy_q   <= '0;
						sxx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						dneg_q  <= acc_q[AW-1];
						state_q <= ST_DABS;
					end
				end
				ST_DABS: begin
					d_q     <= add_sum[AW-1:0];
					pass_q  <= PASS_S_POS;
					state_q <= ST_LOAD;
				end
				ST_NABS: begin
					qneg_q  <= acc_q[AW-1] ^ dneg_q;
					acc_q   <= add_sum[AW-1:0];
					state_q <= ST_NADD;
				end
				ST_NADD: begin
					nq_q    <= add_sum[AW-1:0];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring step; quotient bits shift in behind the dividend.
					rem_q <= add_sum[AW] ? add_sum[AW-1:0] : r_sh;
					nq_q  <= {nq_q[AW-2:0], add_sum[AW]};
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(AW - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (pass_q == PASS_S_NEG) begin
						result_q.slope_out <= signed'(add_sum[OUT_W-1:0]);
						pass_q  <= PASS_I_POS;
						state_q <= ST_LOAD;
					end else begin
						result_q.intercept_out <= signed'(add_sum[OUT_W-1:0]);
						result_q.degenerate    <= 1'b0;
						done_q  <= 1'b1;
						count_q <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						sxy_q   <= '0;
						sxx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: bench/lslf_fit_checker.sv
`timescale 1ns / 1ps

// Watches the point and result channels, keeps its own running sums and
// compares each fit against the oldest one owed.
module lslf_fit_checker
	import lslf_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   busy,
	input  point_t point,
	input  logic   done,
	input  fit_t   result,
	output int     fail_count,
	output int     fits_owed,
	output int     fits_seen,
	output int     degenerate_seen,
	output int     dropped_points
);

	int     set_count;
	longint sum_x;
	longint sum_y;
	longint sum_xy;
	longint sum_xx;
	fit_t   fits_due[$];

	function automatic longint field_value(logic [FIELD_W-1:0] raw);
		longint v;
		v = longint'(raw) & ((longint'(1) << SAMPLE_BITS) - 1);
		if (v[SAMPLE_BITS-1])
			v = v - (longint'(1) << SAMPLE_BITS);
		return v;
	endfunction

	// round(num/den * 2^16), ties away from zero, clamped to the 48-bit range
	function automatic logic [OUT_W-1:0] q31_16_divide(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic         neg;
		logic [127:0] an;
		logic [127:0] ad;
		logic [127:0] q;
		logic [127:0] lim;
		logic [127:0] m;
		neg = num[127] ^ den[127];
		an  = num[127] ? -num : num;
		ad  = den[127] ? -den : den;
		q   = ((an << FRAC_W) + ad) / (ad << 1);
		lim = neg ? {80'd0, NEG_LIMIT} : {80'd0, POS_LIMIT};
		m   = (q > lim) ? lim : q;
		return neg ? -m[OUT_W-1:0] : m[OUT_W-1:0];
	endfunction

	function automatic fit_t solve_line(int n, longint sx, longint sy, longint sxy,
			longint sxx);
		logic signed [127:0] wn;
		logic signed [127:0] wsx;
		logic signed [127:0] wsy;
		logic signed [127:0] wsxy;
		logic signed [127:0] wsxx;
		logic signed [127:0] den;
		fit_t                f;
		wn   = n;
		wsx  = sx;
		wsy  = sy;
		wsxy = sxy;
		wsxx = sxx;
		den  = wn * wsxx - wsx * wsx;
		f    = '0;
		f.degenerate = 1'b1;
		if (n > 1 && den != 0) begin
			f.slope_out     = q31_16_divide(wn * wsxy - wsx * wsy, den);
			f.intercept_out = q31_16_divide(wsy * wsxx - wsx * wsxy, den);
			f.degenerate    = 1'b0;
		end
		return f;
	endfunction

	always @(posedge clk) begin
		fit_t   owed;
		longint x;
		longint y;
		if (!arst_n) begin
			set_count = 0;
			sum_x     = 0;
			sum_y     = 0;
			sum_xy    = 0;
			sum_xx    = 0;
			fits_due.delete();
		end else begin
			// a fit leaving can share the edge with a new point; it belongs to an older set
			if (done) begin
				fits_seen++;
				if (result.degenerate)
					degenerate_seen++;
				if (fits_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected fit: slope %0d intercept %0d degenerate %0b",
							$time, result.slope_out, result.intercept_out,
							result.degenerate);
				end else begin
					owed = fits_due.pop_front();
					if (result !== owed) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t fit exp/got: slope %0d/%0d intcpt %0d/%0d degen %0b/%0b",
								$time, owed.slope_out, result.slope_out,
								owed.intercept_out, result.intercept_out,
								owed.degenerate, result.degenerate);
					end
				end
			end
			if (start && !busy) begin
				x = field_value(point.x_value);
				y = field_value(point.y_value);
				if (set_count < MAX_POINTS) begin
					set_count++;
					sum_x  += x;
					sum_y  += y;
					sum_xy += x * y;
					sum_xx += x * x;
				end else begin
					dropped_points++;
				end
				if (point.last_point) begin
					fits_due.push_back(solve_line(set_count, sum_x, sum_y, sum_xy, sum_xx));
					set_count = 0;
					sum_x     = 0;
					sum_y     = 0;
					sum_xy    = 0;
					sum_xx    = 0;
				end
			end
		end
		fits_owed = fits_due.size();
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// Line fit bench. Points go in one per transaction; each marked-last point
// closes a set and owes one fit, which the checker works out from its own sums
// and compares when done pulses. The receiver side has no backpressure, so
// the only idling is on the sender side.
module tb;
	import lslf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // well above the busy time of one fit
	localparam int TAIL_CYCLES    = 400;
	localparam int ITEMS_TOTAL    = 1250;
	localparam int PHASES         = 4;
	localparam int FITS_PER_PHASE = 4;
	localparam int DIRECTED_N     = 22;
	localparam int FULL_SET_N     = MAX_POINTS_DEF + 3;
	// random points per phase, after the directed points and the full-capacity set
	localparam int PHASE_POINTS   = (ITEMS_TOTAL - DIRECTED_N - FULL_SET_N) / PHASES;

	typedef enum int {
		SET_SPREAD,   // full-range x and y
		SET_SAME_X,   // every x equal: zero denominator
		SET_NARROW,   // small values, exercises rounding
		SET_EXTREME,  // only -32768, -1, 0, 32767
		SET_CORNER    // one (32767, 32767) then all (-32768, -32768): sums near their limits
	} set_kind_t;

	logic   clk;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	logic   busy;
	point_t point  = '0;
	logic   done;
	fit_t   result;

	int fail_count;
	int fits_owed;
	int fits_seen;
	int degenerate_seen;
	int dropped_points;

	int idle_pct;
	int points_sent;
	int sets_sent;
	int stall_cycles;

	// Hand-picked points (x, y, last): single point, equal x, slopes of +1 and -1,
	// steepest possible slope at both ends of x, a slope of exactly one, a
	// fraction that needs rounding, and a mixed-sign set.
	int directed_points [DIRECTED_N][3] = '{
		'{ 32767, -32768, 1},
		'{-32768,      5, 0}, '{-32768,      7, 1},
		'{-32768, -32768, 0}, '{ 32767,  32767, 1},
		'{ 32767, -32768, 0}, '{-32768,  32767, 1},
		'{-32768,  32767, 0}, '{-32767, -32768, 1},
		'{ 32766, -32768, 0}, '{ 32767,  32767, 1},
		'{     3,      3, 0}, '{    10,     10, 1},
		'{     0,      0, 0}, '{     1,      0, 0}, '{     2,      1, 1},
		'{    -1,     -1, 0}, '{     0,      0, 0}, '{     1,      1, 0}, '{    -1,   1, 1},
		'{-32768,      0, 0}, '{ 32767,     -1, 1}
	};

	least_squares_line_fit_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.point  (point),
		.done   (done),
		.result (result)
	);

	lslf_fit_checker u_fit_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.point           (point),
		.done            (done),
		.result          (result),
		.fail_count      (fail_count),
		.fits_owed       (fits_owed),
		.fits_seen       (fits_seen),
		.degenerate_seen (degenerate_seen),
		.dropped_points  (dropped_points)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Nothing moving on either channel for too long means the block hung.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Called and returns at a falling edge. start stays high into the next
	// transaction unless an idle cycle comes first; while busy the point is held.
	task automatic send_point(int x, int y, bit last);
		point_t p;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		p.x_value    = x[FIELD_W-1:0];
		p.y_value    = y[FIELD_W-1:0];
		p.last_point = last;
		start <= 1'b1;
		point <= p;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		points_sent++;
		if (last)
			sets_sent++;
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(3))
			0:       return -32768;
			1:       return -1;
			2:       return 0;
			default: return 32767;
		endcase
	endfunction

	task automatic send_set(int n, set_kind_t kind);
		int shared_x;
		int x;
		int y;
		shared_x = int'($urandom_range(65535)) - 32768;
		for (int i = 0; i < n; i++) begin
			case (kind)
				SET_SAME_X: begin
					x = shared_x;
					y = int'($urandom_range(65535)) - 32768;
				end
				SET_NARROW: begin
					x = int'($urandom_range(16)) - 8;
					y = int'($urandom_range(16)) - 8;
				end
				SET_EXTREME: begin
					x = pick_extreme();
					y = pick_extreme();
				end
				SET_CORNER: begin
					x = (i == 0) ? 32767 : -32768;
					y = x;
				end
				default: begin
					x = int'($urandom_range(65535)) - 32768;
					y = int'($urandom_range(65535)) - 32768;
				end
			endcase
			send_point(x, y, i == n - 1);
		end
	endtask

	// Hold the sender off until the block has handed back every fit owed.
	task automatic drain_fits();
		start <= 1'b0;
		@(negedge clk);
		while (fits_owed != 0)
			@(negedge clk);
	endtask

	initial begin
		int        idle_of_phase [PHASES] = '{0, 73, 20, 0};
		int        phase_points;
		int        phase_sets;
		int        r;
		int        n;
		set_kind_t kind;

		idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_points[i])
			send_point(directed_points[i][0], directed_points[i][1],
				directed_points[i][2] != 0);
		drain_fits();

		// Random sets: mostly short, a few long; the one full-capacity set
		// hits the point limit exactly and then overruns it.
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = idle_of_phase[ph];
			if (ph == 2)
				send_set(FULL_SET_N, SET_CORNER);
			phase_points = points_sent;
			phase_sets   = sets_sent;
			while (points_sent - phase_points < PHASE_POINTS ||
					sets_sent - phase_sets < FITS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 8)
					n = 1;
				else if (r < 70)
					n = $urandom_range(8, 2);
				else if (r < 92)
					n = $urandom_range(30, 9);
				else
					n = $urandom_range(120, 31);
				r = $urandom_range(99);
				if (r < 55)
					kind = SET_SPREAD;
				else if (r < 70)
					kind = SET_SAME_X;
				else if (r < 85)
					kind = SET_NARROW;
				else
					kind = SET_EXTREME;
				if ($urandom_range(9) == 0)
					drain_fits();
				send_set(n, kind);
			end
			drain_fits();
		end

		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Fitted %0d point sets (%0d degenerate) from %0d points over %0d idle phases",
			fits_seen, degenerate_seen, points_sent, PHASES);
		$display("One full-capacity set included; %0d points past the limit were dropped",
			dropped_points);
		if (fail_count == 0 && fits_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
